@@ rtl/cvh_pkg.sv @@
package cvh_pkg;

  localparam int CoordBits  = 16;
  localparam int MaxPoints  = 32;
  localparam int MaxResults = 32;
  localparam int IdxBits    = $clog2(MaxPoints);
  localparam int CntBits    = IdxBits + 1;
  localparam int DiffBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * DiffBits;
  localparam int AccBits    = ProdBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] x_coord;
    logic signed [CoordBits-1:0] y_coord;
    logic                        last_point;
  } pt_in_t;

  typedef struct packed {
    logic [4:0]                  hull_index;
    logic signed [CoordBits-1:0] hull_x;
    logic signed [CoordBits-1:0] hull_y;
    logic                        final_vertex;
    logic                        overflow;
  } hull_out_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } pt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_KEY,
    ST_SORT_STEP,
    ST_CH_INIT,
    ST_CH_P,
    ST_CH_B,
    ST_CH_A,
    ST_MUL,
    ST_DEC,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/convex_hull_monotone_chain.sv @@
// Channel  Dir  Handshake                Beat
// in       in   in_valid_i / in_stall_o  cvh_pkg::pt_in_t    (one point)
// out      out  out_valid_o / out_stall_i cvh_pkg::hull_out_t (one hull vertex)
//
// A point beat is taken while idle; no result follows unless it is the last.
// After the last point: insertion sort, then for each of the n-1 chain points
// a push onto the upper and then the lower chain after its pop tests, every pop test
// on one shared 17x17 multiplier, then one vertex per cycle unless stalled.
// Reset clears all control; point and chain stores hold no reset value.
// The input is stalled from the last point until the final vertex is loaded.
module convex_hull_monotone_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cvh_pkg::pt_in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cvh_pkg::hull_out_t out_data_o
);

  localparam int IB = cvh_pkg::IdxBits;
  localparam int CB = cvh_pkg::CntBits;

  // stores, one read address each per cycle; the upper and lower chain stores share one
  cvh_pkg::pt_t   pts_q [cvh_pkg::MaxPoints];
  logic [IB-1:0]  ord_q [cvh_pkg::MaxPoints];
  logic [IB-1:0]  up_q  [cvh_pkg::MaxPoints];
  logic [IB-1:0]  lo_q  [cvh_pkg::MaxPoints];

  cvh_pkg::state_e state_q, state_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [CB-1:0] i_q, i_d;
  logic [IB-1:0] j_q, j_d;
  logic          upc_q, upc_d;      // working on the upper chain
  logic [CB-1:0] utop_q, utop_d, ltop_q, ltop_d;
  logic [IB-1:0] pidx_q, pidx_d;
  cvh_pkg::pt_t  kp_q, kp_d;        // key point (sort) / new point (chains)
  cvh_pkg::pt_t  bp_q, bp_d, ap_q, ap_d;
  logic [1:0]    mc_q, mc_d;
  logic signed [cvh_pkg::AccBits-1:0] cr_q, cr_d, dt_q, dt_d;
  logic          elo_q, elo_d;      // emitting the lower chain
  logic [IB-1:0] e_q, e_d, k_q, k_d;
  logic          ov_q, ov_d;
  cvh_pkg::hull_out_t od_q, od_d;

  // read ports
  logic [IB-1:0] ord_ra, ch_ra, pts_ra, ord_rd, ch_rd;
  logic          ch_upper;
  cvh_pkg::pt_t  pts_rd;

  // write ports
  logic          pts_we, ord_we, up_we, lo_we;
  logic [IB-1:0] pts_wa, ord_wa, up_wa, lo_wa;
  logic [IB-1:0] ord_wd, up_wd, lo_wd;

  // shared multiplier
  logic signed [cvh_pkg::DiffBits-1:0] ux, uy, vx, vy, mul_a, mul_b;
  logic signed [cvh_pkg::ProdBits-1:0] prod;

  logic          push, pop, load, last_v, key_first;
  logic [IB-1:0] push_j;

  assign ord_rd = ord_q[ord_ra];
  assign ch_rd  = ch_upper ? up_q[ch_ra] : lo_q[ch_ra];
  assign pts_rd = pts_q[pts_ra];

  assign ux = cvh_pkg::DiffBits'(bp_q.x) - cvh_pkg::DiffBits'(ap_q.x);
  assign uy = cvh_pkg::DiffBits'(bp_q.y) - cvh_pkg::DiffBits'(ap_q.y);
  assign vx = cvh_pkg::DiffBits'(kp_q.x) - cvh_pkg::DiffBits'(bp_q.x);
  assign vy = cvh_pkg::DiffBits'(kp_q.y) - cvh_pkg::DiffBits'(bp_q.y);

  always_comb begin
    case (mc_q)
      2'd0:    begin mul_a = ux; mul_b = vy; end
      2'd1:    begin mul_a = uy; mul_b = vx; end
      2'd2:    begin mul_a = ux; mul_b = vx; end
      default: begin mul_a = uy; mul_b = vy; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // sort order: x, then y; ties keep arrival order since the key came later
  assign key_first = (kp_q.x < pts_rd.x) ||
                     ((kp_q.x == pts_rd.x) && (kp_q.y < pts_rd.y));

  // upper pops on a left turn, lower on a right turn, both on a forward overlap
  assign pop = (cr_q == '0) ? (dt_q > 0) : (upc_q ? (cr_q > 0) : (cr_q < 0));

  assign last_v = (k_q == IB'(cvh_pkg::MaxResults - 1)) ||
                  (elo_q ? (e_q == IB'(1))
                         : (({1'b0, e_q} == utop_q - CB'(1)) && (ltop_q < CB'(3))));

  assign in_stall_o  = (state_q != cvh_pkg::ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;   drop_d = drop_q;  i_d = i_q;     j_d = j_q;
    upc_d = upc_q;   utop_d = utop_q;  ltop_d = ltop_q;
    pidx_d = pidx_q; kp_d = kp_q;      bp_d = bp_q;   ap_d = ap_q;
    mc_d = mc_q;     cr_d = cr_q;      dt_d = dt_q;
    elo_d = elo_q;   e_d = e_q;        k_d = k_q;
    ov_d = ov_q && out_stall_i;
    od_d = od_q;
    ord_ra = '0; ch_ra = '0; pts_ra = '0; ch_upper = upc_q;
    pts_we = 1'b0; pts_wa = cnt_q[IB-1:0];
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    up_we = 1'b0;  up_wa = '0;  up_wd = '0;
    lo_we = 1'b0;  lo_wa = '0;  lo_wd = '0;
    push = 1'b0;   push_j = j_q;  load = 1'b0;

    case (state_q)
      cvh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cnt_q < CB'(cvh_pkg::MaxPoints)) begin
            pts_we = 1'b1;
            cnt_d  = cnt_q + CB'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last_point) begin
            ord_we  = 1'b1;
            i_d     = CB'(1);
            state_d = cvh_pkg::ST_SORT_KEY;
          end
        end
      end
      cvh_pkg::ST_SORT_KEY: begin
        pts_ra = i_q[IB-1:0];
        if (i_q == cnt_q) begin
          state_d = cvh_pkg::ST_CH_INIT;
        end else begin
          kp_d    = pts_rd;
          j_d     = i_q[IB-1:0];
          state_d = cvh_pkg::ST_SORT_STEP;
        end
      end
      cvh_pkg::ST_SORT_STEP: begin
        ord_ra = j_q - IB'(1);
        pts_ra = ord_rd;
        ord_we = 1'b1;
        ord_wa = j_q;
        if ((j_q != '0) && key_first) begin
          ord_wd = ord_rd;
          j_d    = j_q - IB'(1);
        end else begin
          ord_wd  = i_q[IB-1:0];
          i_d     = i_q + CB'(1);
          state_d = cvh_pkg::ST_SORT_KEY;
        end
      end
      cvh_pkg::ST_CH_INIT: begin
        up_we  = 1'b1; up_wd = ord_rd;
        lo_we  = 1'b1; lo_wd = ord_rd;
        utop_d = CB'(1);
        ltop_d = CB'(1);
        i_d    = CB'(1);
        if (cnt_q == CB'(1)) begin
          elo_d = 1'b0; e_d = '0; k_d = '0;
          state_d = cvh_pkg::ST_EMIT;
        end else begin
          state_d = cvh_pkg::ST_CH_P;
        end
      end
      cvh_pkg::ST_CH_P: begin
        ord_ra  = i_q[IB-1:0];
        pts_ra  = ord_rd;
        pidx_d  = ord_rd;
        kp_d    = pts_rd;
        upc_d   = 1'b1;
        j_d     = IB'(utop_q - CB'(1));
        state_d = cvh_pkg::ST_CH_B;
      end
      cvh_pkg::ST_CH_B: begin
        ch_ra  = j_q;
        pts_ra = ch_rd;
        if (j_q == '0) begin
          push = 1'b1;
        end else begin
          bp_d    = pts_rd;
          state_d = cvh_pkg::ST_CH_A;
        end
      end
      cvh_pkg::ST_CH_A: begin
        ch_ra   = j_q - IB'(1);
        pts_ra  = ch_rd;
        ap_d    = pts_rd;
        mc_d    = 2'd0;
        state_d = cvh_pkg::ST_MUL;
      end
      cvh_pkg::ST_MUL: begin
        case (mc_q)
          2'd0:    cr_d = cvh_pkg::AccBits'(prod);
          2'd1:    cr_d = cr_q - cvh_pkg::AccBits'(prod);
          2'd2:    dt_d = cvh_pkg::AccBits'(prod);
          default: dt_d = dt_q + cvh_pkg::AccBits'(prod);
        endcase
        mc_d = mc_q + 2'd1;
        if (mc_q == 2'd3) begin
          state_d = cvh_pkg::ST_DEC;
        end
      end
      cvh_pkg::ST_DEC: begin
        if (pop) begin
          j_d = j_q - IB'(1);
          if (j_q == IB'(1)) begin
            push   = 1'b1;
            push_j = '0;
          end else begin
            bp_d    = ap_q;
            state_d = cvh_pkg::ST_CH_A;
          end
        end else begin
          push = 1'b1;
        end
      end
      cvh_pkg::ST_EMIT: begin
        ch_upper = !elo_q;
        ch_ra    = e_q;
        pts_ra   = ch_rd;
        if (!ov_q || !out_stall_i) begin
          load              = 1'b1;
          ov_d              = 1'b1;
          od_d.hull_index   = 5'(ch_rd);
          od_d.hull_x       = pts_rd.x;
          od_d.hull_y       = pts_rd.y;
          od_d.final_vertex = last_v;
          od_d.overflow     = drop_q;
          k_d               = k_q + IB'(1);
          if (last_v) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = cvh_pkg::ST_IDLE;
          end else if (elo_q) begin
            e_d = e_q - IB'(1);
          end else if ({1'b0, e_q} == utop_q - CB'(1)) begin
            elo_d = 1'b1;
            e_d   = IB'(ltop_q - CB'(2));
          end else begin
            e_d = e_q + IB'(1);
          end
        end
      end
      default: state_d = cvh_pkg::ST_IDLE;
    endcase

    // append the new point after the surviving tail, then move on
    if (push) begin
      if (upc_q) begin
        up_we  = 1'b1; up_wa = push_j + IB'(1); up_wd = pidx_q;
        utop_d = CB'(push_j) + CB'(2);
        upc_d  = 1'b0;
        j_d    = IB'(ltop_q - CB'(1));
        state_d = cvh_pkg::ST_CH_B;
      end else begin
        lo_we  = 1'b1; lo_wa = push_j + IB'(1); lo_wd = pidx_q;
        ltop_d = CB'(push_j) + CB'(2);
        i_d    = i_q + CB'(1);
        if (i_q + CB'(1) == cnt_q) begin
          elo_d = 1'b0; e_d = '0; k_d = '0;
          state_d = cvh_pkg::ST_EMIT;
        end else begin
          state_d = cvh_pkg::ST_CH_P;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cvh_pkg::ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      ov_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      upc_q   <= 1'b0;
      utop_q  <= '0;
      ltop_q  <= '0;
      mc_q    <= '0;
      elo_q   <= 1'b0;
      e_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      ov_q    <= ov_d;
      i_q     <= i_d;
      j_q     <= j_d;
      upc_q   <= upc_d;
      utop_q  <= utop_d;
      ltop_q  <= ltop_d;
      mc_q    <= mc_d;
      elo_q   <= elo_d;
      e_q     <= e_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    kp_q   <= kp_d;
    bp_q   <= bp_d;
    ap_q   <= ap_d;
    cr_q   <= cr_d;
    dt_q   <= dt_d;
    od_q   <= od_d;
    if (pts_we) begin
      pts_q[pts_wa] <= '{x: in_data_i.x_coord, y: in_data_i.y_coord};
    end
    if (ord_we) ord_q[ord_wa] <= ord_wd;
    if (up_we)  up_q[up_wa]   <= up_wd;
    if (lo_we)  lo_q[lo_wa]   <= lo_wd;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(cvh_pkg::MaxPoints))
    else $error("point count beyond capacity");

  a_pop_has_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvh_pkg::ST_MUL || state_q == cvh_pkg::ST_DEC) |-> (j_q != '0))
    else $error("pop test without a middle point");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && ov_q && out_stall_i))
    else $error("held vertex overwritten");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_v) |=> (state_q == cvh_pkg::ST_IDLE && cnt_q == '0 && !drop_q))
    else $error("set state not cleared after final vertex");

endmodule

@@ verif/convex_hull_monotone_chain_test.sv @@
`timescale 1ns / 100ps

module convex_hull_monotone_chain_test;

  localparam int Capacity   = cvh_pkg::MaxPoints;
  localparam int VertexCap  = cvh_pkg::MaxResults;
  localparam int IdleLimit  = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  cvh_pkg::pt_in_t    in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  cvh_pkg::hull_out_t out_data_o;

  convex_hull_monotone_chain DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: points of the open set and the drop flag.
  cvh_pkg::pt_t       set_pts[Capacity];
  int                 set_count = 0;
  bit                 set_dropped = 1'b0;
  cvh_pkg::hull_out_t hull_queue[$];
  int                 errors = 0;
  int                 idle_cycles = 0;

  // Strict sort order: x, then y, then arrival.
  function automatic bit sorts_first(int a, int b);
    if (set_pts[a].x != set_pts[b].x) return set_pts[a].x < set_pts[b].x;
    if (set_pts[a].y != set_pts[b].y) return set_pts[a].y < set_pts[b].y;
    return a < b;
  endfunction

  function automatic bit pops_vertex(cvh_pkg::pt_t a, cvh_pkg::pt_t b, cvh_pkg::pt_t p,
                                     bit upper);
    longint ux, uy, vx, vy, cr, dt;
    ux = longint'(b.x) - a.x;  uy = longint'(b.y) - a.y;
    vx = longint'(p.x) - b.x;  vy = longint'(p.y) - b.y;
    cr = ux * vy - uy * vx;
    dt = ux * vx + uy * vy;
    if (cr == 0) return dt > 0;
    return upper ? (cr > 0) : (cr < 0);
  endfunction

  // Andrew's monotone chain over the stored set; queues expected vertices.
  task automatic predict_hull();
    int order[Capacity];
    int up[Capacity], lo[Capacity];
    int n, ut, lt, j, key, k, total;
    cvh_pkg::hull_out_t v;
    n = set_count;
    if (n > 0) begin
      for (int i = 0; i < n; i++) order[i] = i;
      for (int i = 1; i < n; i++) begin
        key = order[i];
        j = i;
        while (j > 0 && sorts_first(key, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = key;
      end
      up[0] = 0; lo[0] = 0; ut = 1; lt = 1;
      for (int i = 1; i < n; i++) begin
        j = ut - 1;
        while (j > 0 && pops_vertex(set_pts[order[up[j-1]]], set_pts[order[up[j]]],
                                    set_pts[order[i]], 1'b1)) j--;
        up[j+1] = i; ut = j + 2;
        j = lt - 1;
        while (j > 0 && pops_vertex(set_pts[order[lo[j-1]]], set_pts[order[lo[j]]],
                                    set_pts[order[i]], 1'b0)) j--;
        lo[j+1] = i; lt = j + 2;
      end
      // lower chain adds its interior only
      total = ut + ((lt > 2) ? lt - 2 : 0);
      k = 0;
      for (int i = 0; i < total && k < VertexCap; i++) begin
        key = (i < ut) ? order[up[i]] : order[lo[lt - 2 - (i - ut)]];
        v.hull_index   = key[4:0];
        v.hull_x       = set_pts[key].x;
        v.hull_y       = set_pts[key].y;
        v.final_vertex = 1'b0;
        v.overflow     = set_dropped;
        hull_queue = {hull_queue, v};
        k++;
      end
      hull_queue[$].final_vertex = 1'b1;
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one point beat; model it once accepted. Valid drops only in a gap.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{x_coord: x, y_coord: y, last_point: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (set_count < Capacity) begin
      set_pts[set_count] = '{x: x, y: y};
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) predict_hull();
  endtask

  task automatic send_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_point(16'($signed($urandom_range(0, 2*span)) - span),
                 16'($signed($urandom_range(0, 2*span)) - span), i == n - 1);
  endtask

  task automatic test_small_sets();
    send_point(16'sd5, -16'sd7, 1'b1);                    // single point
    send_point(16'sh8000, 16'sh7fff, 1'b0);               // two points, extremes
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0);               // extreme corners
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
  endtask

  task automatic test_degenerate();
    // duplicates and collinear points
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd3, 16'sd3, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_capacity();
    // overflow with many tiny coordinates so duplicates pile up too
    send_set(Capacity + 3, 2);
    send_set(Capacity, 32767);
  endtask

  task automatic test_random_sets();
    int sent;
    sent = 0;
    while (sent < 80) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 10);
      send_set(n, ($urandom_range(0, 2) == 0) ? 3 : 32767);
      sent += n;
    end
  endtask

  // Receiver stall pattern.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hull_queue.size() == 0) begin
        $display("%0t: unexpected vertex %p", $time, out_data_o);
        errors++;
      end else begin
        cvh_pkg::hull_out_t e;
        e = hull_queue.pop_front();
        if (out_data_o !== e) begin
          $display("%0t: vertex mismatch expected %p actual %p", $time, e, out_data_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL convex_hull_monotone_chain");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_sets();
    test_degenerate();
    test_capacity();
    test_random_sets();
    in_valid_i <= 1'b0;
    while (hull_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS convex_hull_monotone_chain");
    end else begin
      $display("FAIL convex_hull_monotone_chain");
    end
    $finish;
  end

endmodule
